// ----- rtl/json_path_event_matcher_top_macros.svh -----
// ---------------------------------------------------------------------------
// JSON path event matcher assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef JSON_PATH_EVENT_MATCHER_TOP_MACROS_SVH
`define JSON_PATH_EVENT_MATCHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define JPEM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Check a property on every clock edge, reset included
`define JPEM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);
`else
`define JPEM_ASSERT(label, prop, msg)
`define JPEM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- rtl/jpem_pkg.sv -----
// ---------------------------------------------------------------------------
// JSON path event matcher package
// Widths, codes, configuration record and the byte compare function.
// ---------------------------------------------------------------------------
package jpem_pkg;

    // Sizes of the path and the nesting counter
    localparam int MAX_SEGMENTS = 3;
    localparam int NAME_BYTES   = 8;
    localparam int DEPTH_BITS   = 8;

    localparam int TEXT_BYTES = 8;
    localparam int TEXT_W     = 8 * TEXT_BYTES;
    localparam int LEN_W      = 4;
    localparam int OP_W       = 3;
    localparam int MD_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SEG_LENS_W = 12;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX    = '1;
    localparam logic [LEN_W-1:0]      WILDCARD_LEN = 4'd15;

    // Event codes
    typedef enum logic [OP_W-1:0] {
        OP_DOC_START = 3'd0,
        OP_OPEN      = 3'd1,
        OP_CLOSE     = 3'd2,
        OP_KEY       = 3'd3,
        OP_SCALAR    = 3'd4
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEG_NAME_ONE   = 3'd0,
        CFG_SEG_NAME_TWO   = 3'd1,
        CFG_SEG_NAME_THREE = 3'd2,
        CFG_SEG_LENGTHS    = 3'd3,
        CFG_SEG_COUNT      = 3'd4,
        CFG_MATCH_VALUE    = 3'd5,
        CFG_VALUE_LENGTH   = 3'd6
    } t_cfg_idx;

    // Configuration contents seen by the matcher
    typedef struct packed {
        logic [TEXT_W-1:0]     seg_name_one;
        logic [TEXT_W-1:0]     seg_name_two;
        logic [TEXT_W-1:0]     seg_name_three;
        logic [SEG_LENS_W-1:0] seg_lengths;
        logic [MD_W-1:0]       seg_count;
        logic [TEXT_W-1:0]     match_value;
        logic [LEN_W-1:0]      value_length;
    } t_cfg;

    // Equal lengths within limit and equal leading bytes
    function automatic logic bytes_equal(
        input logic [TEXT_W-1:0] want,
        input logic [LEN_W-1:0]  want_len,
        input logic [LEN_W-1:0]  limit,
        input logic [TEXT_W-1:0] got,
        input logic [LEN_W-1:0]  got_len
    );
        logic [TEXT_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < TEXT_BYTES; b++) begin
            if (b < int'(want_len)) begin
                mask[8*b +: 8] = 8'hFF;
            end
        end
        return (want_len <= limit) && (got_len <= LEN_W'(TEXT_BYTES)) &&
               (want_len == got_len) && ((want & mask) == (got & mask));
    endfunction

endpackage

// ----- rtl/jpem_ifs.sv -----
// ---------------------------------------------------------------------------
// JSON path event matcher channels
// Valid/ready channels for parser events and match results.
// ---------------------------------------------------------------------------
interface jpem_in_if;
    import jpem_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [TEXT_W-1:0]    text;
    logic [LEN_W-1:0]     text_length;

    modport source (output valid, output opcode, output text, output text_length,
                    input ready);
    modport sink   (input valid, input opcode, input text, input text_length,
                    output ready);
endinterface

interface jpem_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// ----- rtl/jpem_cfg.sv -----
// ---------------------------------------------------------------------------
// JSON path event matcher configuration registers
// Decodes register writes and holds the path and value setup.
// ---------------------------------------------------------------------------
module jpem_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jpem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [jpem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output jpem_pkg::t_cfg                   o_cfg
);
    import jpem_pkg::*;

    t_cfg r_cfg;

    // Write one register per enabled cycle, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_name_one   <= '0;
            r_cfg.seg_name_two   <= '0;
            r_cfg.seg_name_three <= '0;
            r_cfg.seg_lengths    <= '0;
            r_cfg.seg_count      <= '0;
            r_cfg.match_value    <= '0;
            r_cfg.value_length   <= WILDCARD_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEG_NAME_ONE:   r_cfg.seg_name_one   <= i_cfg_data[TEXT_W-1:0];
                CFG_SEG_NAME_TWO:   r_cfg.seg_name_two   <= i_cfg_data[TEXT_W-1:0];
                CFG_SEG_NAME_THREE: r_cfg.seg_name_three <= i_cfg_data[TEXT_W-1:0];
                CFG_SEG_LENGTHS:    r_cfg.seg_lengths    <= i_cfg_data[SEG_LENS_W-1:0];
                CFG_SEG_COUNT:      r_cfg.seg_count      <= i_cfg_data[MD_W-1:0];
                CFG_MATCH_VALUE:    r_cfg.match_value    <= i_cfg_data[TEXT_W-1:0];
                CFG_VALUE_LENGTH:   r_cfg.value_length   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/jpem_core.sv -----
// ---------------------------------------------------------------------------
// JSON path event matcher core
// Input register, depth and path tracking, and the result register.
// ---------------------------------------------------------------------------
`include "json_path_event_matcher_top_macros.svh"

module jpem_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jpem_pkg::t_cfg i_cfg,
    jpem_in_if.sink        i_in,
    jpem_out_if.source     o_out
);
    import jpem_pkg::*;

    // Input register
    logic                  r_in_valid;
    logic [OP_W-1:0]       r_in_op;
    logic [TEXT_W-1:0]     r_in_text;
    logic [LEN_W-1:0]      r_in_len;

    // Tracking state
    logic [DEPTH_BITS-1:0] r_depth;
    logic [MD_W-1:0]       r_md;
    logic                  r_dm;

    // Result register
    logic                  r_out_valid;
    logic                  r_out_matched;

    logic                  w_out_free;
    logic                  w_adv;
    logic                  w_in_take;

    logic [DEPTH_BITS-1:0] n_depth;
    logic [MD_W-1:0]       n_md;
    logic                  n_dm;

    logic [MD_W-1:0]       w_cnt;
    logic [DEPTH_BITS-1:0] w_parent;
    logic [MD_W-1:0]       w_md_key;
    logic [LEN_W-1:0]      w_seg_len;
    logic [TEXT_W-1:0]     w_seg_name;
    logic                  w_key_hit;
    logic                  w_val_hit;

    // Handshake: advance when the result slot is empty or being drained
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in.valid && i_in.ready;

    // Clamp the segment count to the path size
    assign w_cnt = (int'(i_cfg.seg_count) > MAX_SEGMENTS) ? MD_W'(MAX_SEGMENTS)
                                                          : i_cfg.seg_count;

    // Drop the matched depth to the key's parent level
    assign w_parent = (r_depth != '0) ? (r_depth - DEPTH_BITS'(1)) : r_depth;
    assign w_md_key = (DEPTH_BITS'(r_md) > w_parent) ? w_parent[MD_W-1:0] : r_md;

    // Select the segment that the next key must match
    always_comb begin
        unique case (w_md_key)
            2'd0: begin
                w_seg_len  = i_cfg.seg_lengths[LEN_W-1:0];
                w_seg_name = i_cfg.seg_name_one;
            end
            2'd1: begin
                w_seg_len  = i_cfg.seg_lengths[2*LEN_W-1:LEN_W];
                w_seg_name = i_cfg.seg_name_two;
            end
            default: begin
                w_seg_len  = i_cfg.seg_lengths[3*LEN_W-1:2*LEN_W];
                w_seg_name = i_cfg.seg_name_three;
            end
        endcase
    end

    // Compare the key against the segment and the scalar against the value
    assign w_key_hit = (w_seg_len == WILDCARD_LEN) ||
                       bytes_equal(w_seg_name, w_seg_len, LEN_W'(NAME_BYTES),
                                   r_in_text, r_in_len);
    assign w_val_hit = (i_cfg.value_length == WILDCARD_LEN) ||
                       bytes_equal(i_cfg.match_value, i_cfg.value_length,
                                   LEN_W'(TEXT_BYTES), r_in_text, r_in_len);

    // Next tracking state for the held item
    always_comb begin
        n_depth = r_depth;
        n_md    = r_md;
        n_dm    = r_dm;
        if (r_in_op == OP_DOC_START) begin
            n_depth = '0;
            n_md    = '0;
            n_dm    = 1'b0;
        end else if (!r_dm) begin
            unique case (r_in_op)
                OP_OPEN: begin
                    if (r_depth != DEPTH_MAX) begin
                        n_depth = r_depth + DEPTH_BITS'(1);
                    end
                end
                OP_CLOSE: begin
                    n_depth = (r_depth != '0) ? (r_depth - DEPTH_BITS'(1)) : r_depth;
                    if (DEPTH_BITS'(r_md) > n_depth) begin
                        n_md = n_depth[MD_W-1:0];
                    end
                end
                OP_KEY: begin
                    n_md = w_md_key;
                    if (((DEPTH_BITS+1)'(w_md_key) + (DEPTH_BITS+1)'(1) ==
                         (DEPTH_BITS+1)'(r_depth)) &&
                        (w_md_key < w_cnt) && w_key_hit) begin
                        n_md = w_md_key + MD_W'(1);
                    end
                end
                OP_SCALAR: begin
                    if ((w_cnt != '0) && (DEPTH_BITS'(r_md) == r_depth) &&
                        (r_md == w_cnt) && w_val_hit) begin
                        n_dm = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the accepted item until it moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op   <= i_in.opcode;
            r_in_text <= i_in.text;
            r_in_len  <= i_in.text_length;
        end
    end

    // Advance tracking state and load the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_md        <= '0;
            r_dm        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_depth     <= n_depth;
            r_md        <= n_md;
            r_dm        <= n_dm;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_matched <= n_dm;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.matched = r_out_matched;

    `JPEM_ASSERT(a_md_within_depth, (DEPTH_BITS'(r_md) <= r_depth), "matched depth above nesting depth")
    `JPEM_ASSERT(a_match_frozen, (w_adv && r_dm && (r_in_op != OP_DOC_START)) |=> r_dm, "match flag dropped without document start")
    `JPEM_ASSERT(a_doc_start_clears, (w_adv && (r_in_op == OP_DOC_START)) |=> ((r_depth == '0) && (r_md == '0) && !r_dm), "document start left state behind")
    `JPEM_ASSERT(a_result_tracks_state, r_out_valid |-> (r_out_matched == r_dm), "pending result differs from match flag")
    `JPEM_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

// ----- rtl/json_path_event_matcher_top.sv -----
// A result is loaded into the result register when its event leaves the input register.
// Throughput: one event per cycle; while a result waits the input register
// holds one more event, then input stalls until the result drains.
// Reset: synchronous, active low; clears depth, matched path and match flag,
// empties both stages and loads the configuration reset values.
// ---------------------------------------------------------------------------
// JSON path event matcher top level
// Matches a configured key path and scalar value over parser events.
// ---------------------------------------------------------------------------
module json_path_event_matcher_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jpem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [jpem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    jpem_in_if.sink                          i_in,
    jpem_out_if.source                       o_out
);
    import jpem_pkg::*;

    t_cfg w_cfg;

    // Configuration registers
    jpem_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Event tracking and result stage
    jpem_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
